// ----- rtl/s2a_pkg.sv -----
`default_nettype none

package s2a_pkg;

    // scan code set 1 byte layout
    localparam logic [7:0] PREFIX_BYTE  = 8'hE0;
    localparam logic [6:0] KEY_CTRL     = 7'h1D;
    localparam logic [6:0] KEY_LSHF     = 7'h2A;
    localparam logic [6:0] KEY_RSHF     = 7'h36;
    localparam logic [6:0] KEY_ALT      = 7'h38;
    localparam logic [6:0] KEY_CAPS     = 7'h3A;
    localparam logic [6:0] KEY_NUM      = 7'h45;
    localparam logic [6:0] KEY_SCROLL   = 7'h46;
    localparam logic [6:0] CTRL_LO      = 7'h1E;
    localparam logic [6:0] CTRL_HI      = 7'h39;
    localparam logic [6:0] TABLE_SIZE   = 7'h3A;
    localparam logic [6:0] CHAR_LOWER_A = 7'h61;
    localparam logic [6:0] CHAR_LOWER_Z = 7'h7A;
    localparam logic [6:0] CHAR_NONE    = 7'h00;

    typedef logic [7:0] scan_byte_t;
    typedef logic [6:0] ascii_t;

    // keyboard modifier and lock flags
    typedef struct packed {
        logic prefix;
        logic shift;
        logic ctrl;
        logic alt;
        logic caps;
        logic num;
        logic scroll;
    } kbd_flags_t;

    // unshifted us layout, keys 0x00..0x39
    function automatic ascii_t plain_char(input logic [5:0] key);
        ascii_t c;
        begin
            case (key)
                6'h02:   c = 7'h31;
                6'h03:   c = 7'h32;
                6'h04:   c = 7'h33;
                6'h05:   c = 7'h34;
                6'h06:   c = 7'h35;
                6'h07:   c = 7'h36;
                6'h08:   c = 7'h37;
                6'h09:   c = 7'h38;
                6'h0A:   c = 7'h39;
                6'h0B:   c = 7'h30;
                6'h0C:   c = 7'h2D;
                6'h0D:   c = 7'h3D;
                6'h0E:   c = 7'h08;
                6'h0F:   c = 7'h09;
                6'h10:   c = 7'h71;
                6'h11:   c = 7'h77;
                6'h12:   c = 7'h65;
                6'h13:   c = 7'h72;
                6'h14:   c = 7'h74;
                6'h15:   c = 7'h79;
                6'h16:   c = 7'h75;
                6'h17:   c = 7'h69;
                6'h18:   c = 7'h6F;
                6'h19:   c = 7'h70;
                6'h1A:   c = 7'h5B;
                6'h1B:   c = 7'h5D;
                6'h1C:   c = 7'h0A;
                6'h1E:   c = 7'h61;
                6'h1F:   c = 7'h73;
                6'h20:   c = 7'h64;
                6'h21:   c = 7'h66;
                6'h22:   c = 7'h67;
                6'h23:   c = 7'h68;
                6'h24:   c = 7'h6A;
                6'h25:   c = 7'h6B;
                6'h26:   c = 7'h6C;
                6'h27:   c = 7'h3B;
                6'h28:   c = 7'h27;
                6'h29:   c = 7'h60;
                6'h2B:   c = 7'h5C;
                6'h2C:   c = 7'h7A;
                6'h2D:   c = 7'h78;
                6'h2E:   c = 7'h63;
                6'h2F:   c = 7'h76;
                6'h30:   c = 7'h62;
                6'h31:   c = 7'h6E;
                6'h32:   c = 7'h6D;
                6'h33:   c = 7'h2C;
                6'h34:   c = 7'h2E;
                6'h35:   c = 7'h2F;
                6'h37:   c = 7'h2A;
                6'h39:   c = 7'h20;
                default: c = CHAR_NONE;
            endcase
            return c;
        end
    endfunction

    // shifted us layout, keys 0x00..0x39
    function automatic ascii_t shifted_char(input logic [5:0] key);
        ascii_t c;
        begin
            case (key)
                6'h02:   c = 7'h21;
                6'h03:   c = 7'h40;
                6'h04:   c = 7'h23;
                6'h05:   c = 7'h24;
                6'h06:   c = 7'h25;
                6'h07:   c = 7'h5E;
                6'h08:   c = 7'h26;
                6'h09:   c = 7'h2A;
                6'h0A:   c = 7'h28;
                6'h0B:   c = 7'h29;
                6'h0C:   c = 7'h5F;
                6'h0D:   c = 7'h2B;
                6'h0E:   c = 7'h08;
                6'h0F:   c = 7'h09;
                6'h10:   c = 7'h51;
                6'h11:   c = 7'h57;
                6'h12:   c = 7'h45;
                6'h13:   c = 7'h52;
                6'h14:   c = 7'h54;
                6'h15:   c = 7'h59;
                6'h16:   c = 7'h55;
                6'h17:   c = 7'h49;
                6'h18:   c = 7'h4F;
                6'h19:   c = 7'h50;
                6'h1A:   c = 7'h7B;
                6'h1B:   c = 7'h7D;
                6'h1C:   c = 7'h0A;
                6'h1E:   c = 7'h41;
                6'h1F:   c = 7'h53;
                6'h20:   c = 7'h44;
                6'h21:   c = 7'h46;
                6'h22:   c = 7'h47;
                6'h23:   c = 7'h48;
                6'h24:   c = 7'h4A;
                6'h25:   c = 7'h4B;
                6'h26:   c = 7'h4C;
                6'h27:   c = 7'h3A;
                6'h28:   c = 7'h22;
                6'h29:   c = 7'h7E;
                6'h2B:   c = 7'h7C;
                6'h2C:   c = 7'h5A;
                6'h2D:   c = 7'h58;
                6'h2E:   c = 7'h43;
                6'h2F:   c = 7'h56;
                6'h30:   c = 7'h42;
                6'h31:   c = 7'h4E;
                6'h32:   c = 7'h4D;
                6'h33:   c = 7'h3C;
                6'h34:   c = 7'h3E;
                6'h35:   c = 7'h3F;
                6'h37:   c = 7'h2A;
                6'h39:   c = 7'h20;
                default: c = CHAR_NONE;
            endcase
            return c;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/s2a_state.sv -----
`default_nettype none

module s2a_state (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    input  wire s2a_pkg::scan_byte_t scan_byte,
    output s2a_pkg::kbd_flags_t      flags_cur,
    output s2a_pkg::kbd_flags_t      flags_nxt
);
    import s2a_pkg::*;

    kbd_flags_t flags_reg;
    kbd_flags_t flags_next;
    logic [6:0] key;
    logic       pressed;

    assign key     = scan_byte[6:0];
    assign pressed = ~scan_byte[7];

    always_comb
    begin
        flags_next = flags_reg;
        if (scan_byte == PREFIX_BYTE)
        begin
            flags_next.prefix = 1'b1;
        end
        else if (flags_reg.prefix)
        begin
            // right ctrl / right alt; other extended keys only drop the prefix
            flags_next.prefix = 1'b0;
            if (key == KEY_CTRL)
            begin
                flags_next.ctrl = pressed;
            end
            else if (key == KEY_ALT)
            begin
                flags_next.alt = pressed;
            end
        end
        else
        begin
            case (key)
                KEY_LSHF, KEY_RSHF: flags_next.shift = pressed;
                KEY_CTRL:           flags_next.ctrl  = pressed;
                KEY_ALT:            flags_next.alt   = pressed;
                KEY_CAPS:           flags_next.caps   = flags_reg.caps ^ pressed;
                KEY_NUM:            flags_next.num    = flags_reg.num ^ pressed;
                KEY_SCROLL:         flags_next.scroll = flags_reg.scroll ^ pressed;
                default:            flags_next = flags_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (advance)
        begin
            flags_reg <= flags_next;
        end
    end

    assign flags_cur = flags_reg;
    assign flags_nxt = flags_next;

endmodule

`default_nettype wire

// ----- rtl/s2a_xlate.sv -----
`default_nettype none

module s2a_xlate (
    input  wire s2a_pkg::scan_byte_t scan_byte,
    input  wire s2a_pkg::kbd_flags_t flags,
    output s2a_pkg::ascii_t          char_code
);
    import s2a_pkg::*;

    logic [6:0] key;
    ascii_t     base_char;
    ascii_t     shift_char;
    logic       ctrl_range;
    logic       is_letter;

    assign key        = scan_byte[6:0];
    assign base_char  = plain_char(key[5:0]);
    assign shift_char = shifted_char(key[5:0]);
    assign ctrl_range = (key >= CTRL_LO) && (key <= CTRL_HI);
    assign is_letter  = (base_char >= CHAR_LOWER_A) && (base_char <= CHAR_LOWER_Z);

    always_comb
    begin
        if (scan_byte[7] || flags.prefix || (key >= TABLE_SIZE))
        begin
            char_code = CHAR_NONE;
        end
        else if (flags.ctrl && ctrl_range && is_letter)
        begin
            // control codes 1..26
            char_code = base_char - CHAR_LOWER_A + 7'd1;
        end
        else if (flags.shift ^ flags.caps)
        begin
            char_code = shift_char;
        end
        else
        begin
            char_code = base_char;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/scancode_to_ascii_translator.sv -----
`default_nettype none

// channel  | direction | handshake                   | payload
// ---------+-----------+-----------------------------+----------------------------------
// scan     | in        | scan_valid / scan_stall     | scan_byte[7:0]
// result   | out       | result_valid / result_stall | char_code[6:0], shift_down,
//          |           |                             | ctrl_down, alt_down, caps_on,
//          |           |                             | num_on, scroll_on
//
// one item per cycle sustained while result_stall is low; a scan item goes
// through the input register, then translation and flag update into the
// result register, where result_valid rises
// rst_n clears both stage valids and all keyboard flags
// result_stall holds the result register; the input register still takes an
// item when it is empty, so one byte can wait behind a stalled result

module scancode_to_ascii_translator (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // scan byte channel
    input  wire logic                scan_valid,
    output logic                     scan_stall,
    input  wire s2a_pkg::scan_byte_t scan_byte,
    // result channel
    output logic                     result_valid,
    input  wire logic                result_stall,
    output s2a_pkg::ascii_t          char_code,
    output logic                     shift_down,
    output logic                     ctrl_down,
    output logic                     alt_down,
    output logic                     caps_on,
    output logic                     num_on,
    output logic                     scroll_on
);
    import s2a_pkg::*;

    // input stage
    logic       in_valid_reg;
    scan_byte_t in_byte_reg;

    // result stage
    logic       res_valid_reg;
    ascii_t     res_char_reg;
    kbd_flags_t res_flags_reg;

    logic       res_free;   // result register can take a new item
    logic       advance;    // input stage moves into result stage
    logic       take_in;    // scan item accepted

    kbd_flags_t flags_cur;
    kbd_flags_t flags_nxt;
    ascii_t     xlate_char;

    assign res_free   = ~res_valid_reg | ~result_stall;
    assign advance    = in_valid_reg & res_free;
    assign scan_stall = in_valid_reg & ~res_free;
    assign take_in    = scan_valid & ~scan_stall;

    // flags advance only with the byte that leaves the input stage,
    // so every byte sees the state left by the one before it
    s2a_state u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .scan_byte (in_byte_reg),
        .flags_cur (flags_cur),
        .flags_nxt (flags_nxt)
    );

    // character is looked up against the flags before this byte
    s2a_xlate u_xlate (
        .scan_byte (in_byte_reg),
        .flags     (flags_cur),
        .char_code (xlate_char)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (take_in)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (res_free)
            begin
                res_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_byte_reg <= scan_byte;
        end
        if (advance)
        begin
            res_char_reg  <= xlate_char;
            res_flags_reg <= flags_nxt;
        end
    end

    assign result_valid = res_valid_reg;
    assign char_code    = res_char_reg;
    assign shift_down   = res_flags_reg.shift;
    assign ctrl_down    = res_flags_reg.ctrl;
    assign alt_down     = res_flags_reg.alt;
    assign caps_on      = res_flags_reg.caps;
    assign num_on       = res_flags_reg.num;
    assign scroll_on    = res_flags_reg.scroll;

endmodule

`default_nettype wire

// ----- tb/scancode_to_ascii_translator_test.sv -----
`default_nettype none

module scancode_to_ascii_translator_test;

    timeunit 1ns;
    timeprecision 1ps;

    import s2a_pkg::*;

    // watchdog limit: idle cycles in a row with no item moving on either side
    localparam int IDLE_LIMIT = 2000;
    // cycles to wait after the last result, pipeline is two stages deep
    localparam int DRAIN_CYCLES = 8;
    // least number of scan items in the whole run
    localparam int ITEM_TARGET = 650;

    // one translated item as seen on the result side
    typedef struct packed {
        ascii_t ch;
        logic   shift;
        logic   ctrl;
        logic   alt;
        logic   caps;
        logic   num;
        logic   scroll;
    } key_result_t;

    // keyboard state tracker plus queue of characters still to come out
    class keystroke_board;

        // us layout, keys 0x00..0x39
        ascii_t plain_tbl[58] = '{
            7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
            7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
            7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
            7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
            7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
            7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
            7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
            7'h00, 7'h20
        };
        ascii_t shifted_tbl[58] = '{
            7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
            7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
            7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
            7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
            7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
            7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
            7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
            7'h00, 7'h20
        };

        kbd_flags_t  flags = '0;
        key_result_t pending_chars[$];
        int          mismatches = 0;
        int unsigned results_seen = 0;

        function int pending();
            return pending_chars.size();
        endfunction

        // translate against the old flags, then let the byte update them
        function void note_scan(scan_byte_t b);
            logic [6:0]  key;
            logic        pressed;
            ascii_t      ch;
            key_result_t r;
            key = b[6:0];
            pressed = !b[7];
            ch = CHAR_NONE;
            if (pressed && !flags.prefix && key < TABLE_SIZE)
            begin
                if (flags.shift != flags.caps)
                    ch = shifted_tbl[key[5:0]];
                else
                    ch = plain_tbl[key[5:0]];
                // ctrl plus letter in the home and bottom letter rows
                if (flags.ctrl && key >= CTRL_LO && key <= CTRL_HI &&
                    plain_tbl[key[5:0]] >= CHAR_LOWER_A &&
                    plain_tbl[key[5:0]] <= CHAR_LOWER_Z)
                    ch = plain_tbl[key[5:0]] - CHAR_LOWER_A + 7'd1;
            end
            if (b == PREFIX_BYTE)
            begin
                flags.prefix = 1'b1;
            end
            else if (flags.prefix)
            begin
                if (key == KEY_CTRL)
                    flags.ctrl = pressed;
                else if (key == KEY_ALT)
                    flags.alt = pressed;
                flags.prefix = 1'b0;
            end
            else
            begin
                case (key)
                    KEY_LSHF, KEY_RSHF: flags.shift = pressed;
                    KEY_CTRL:           flags.ctrl = pressed;
                    KEY_ALT:            flags.alt = pressed;
                    KEY_CAPS:           if (pressed) flags.caps = !flags.caps;
                    KEY_NUM:            if (pressed) flags.num = !flags.num;
                    KEY_SCROLL:         if (pressed) flags.scroll = !flags.scroll;
                    default:            ;
                endcase
            end
            r.ch = ch;
            r.shift = flags.shift;
            r.ctrl = flags.ctrl;
            r.alt = flags.alt;
            r.caps = flags.caps;
            r.num = flags.num;
            r.scroll = flags.scroll;
            pending_chars.push_back(r);
        endfunction

        function void check_char(key_result_t got);
            key_result_t want;
            bit          bad;
            results_seen++;
            if (pending_chars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with nothing pending: char %h", results_seen,
                             got.ch);
                return;
            end
            want = pending_chars.pop_front();
            bad = (got.ch !== want.ch) || (got.shift !== want.shift) ||
                  (got.ctrl !== want.ctrl) || (got.alt !== want.alt) ||
                  (got.caps !== want.caps) || (got.num !== want.num) ||
                  (got.scroll !== want.scroll);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: expected char %h s%b c%b a%b cl%b nl%b sl%b,",
                             results_seen, want.ch, want.shift, want.ctrl, want.alt,
                             want.caps, want.num, want.scroll,
                             " got char %h s%b c%b a%b cl%b nl%b sl%b",
                             got.ch, got.shift, got.ctrl,
                             got.alt, got.caps, got.num, got.scroll);
            end
        endfunction

    endclass

    logic       clk;
    logic       rst_n;
    logic       scan_valid;
    logic       scan_stall;
    scan_byte_t scan_byte;
    logic       result_valid;
    logic       result_stall;
    ascii_t     char_code;
    logic       shift_down;
    logic       ctrl_down;
    logic       alt_down;
    logic       caps_on;
    logic       num_on;
    logic       scroll_on;

    keystroke_board board = new();

    // when set, neither side idles, so back-to-back items get through
    bit quiet = 1'b0;
    int idle_cycles = 0;

    scancode_to_ascii_translator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .scan_valid   (scan_valid),
        .scan_stall   (scan_stall),
        .scan_byte    (scan_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .char_code    (char_code),
        .shift_down   (shift_down),
        .ctrl_down    (ctrl_down),
        .alt_down     (alt_down),
        .caps_on      (caps_on),
        .num_on       (num_on),
        .scroll_on    (scroll_on)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // idle length: mostly none or short, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 40);
    endfunction

    // monitor: both handshakes are sampled at the rising edge, before the
    // block's registers move, and feed the board in acceptance order
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (scan_valid && !scan_stall)
                board.note_scan(scan_byte);
            if (result_valid && !result_stall)
                board.check_char({char_code, shift_down, ctrl_down, alt_down, caps_on, num_on,
                                  scroll_on});
        end
    end

    // watchdog: a run where nothing moves for too long is a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((scan_valid && !scan_stall) || (result_valid && !result_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // receiver back-pressure: stall bursts of random length, changed at the
    // falling edge only, none while the quiet stretch is on
    initial
    begin
        int n;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = quiet ? 0 : idle_len();
            if (n > 0)
            begin
                result_stall = 1'b1;
                repeat (n) @(negedge clk);
            end
            result_stall = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    end

    // offer one item; called at a falling edge and returns at a falling edge
    // once the item has been taken, valid stays high into the next item
    // unless a gap is chosen
    task automatic send_scan(input scan_byte_t b);
        int gap;
        gap = quiet ? 0 : idle_len();
        if (gap > 0)
        begin
            scan_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        scan_valid = 1'b1;
        scan_byte = b;
        do
            @(posedge clk);
        while (scan_stall);
        @(negedge clk);
    endtask

    // press then release of one key
    task automatic tap_key(input logic [6:0] key);
        send_scan({1'b0, key});
        send_scan({1'b1, key});
    endtask

    initial
    begin
        int sent;
        int r;
        logic [6:0] key;
        rst_n = 1'b0;
        scan_valid = 1'b0;
        scan_byte = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: table ends, shift and caps, ctrl letters, prefix handling
        send_scan(8'h00);                   // lowest code, no character
        send_scan(8'h1E);                   // plain 'a'
        send_scan({1'b0, KEY_LSHF});
        send_scan(8'h02);                   // shifted digit
        send_scan({1'b1, KEY_LSHF});
        send_scan({1'b0, KEY_CAPS});
        send_scan(8'h02);                   // caps shifts digits as well
        send_scan({1'b0, KEY_CAPS});        // caps back off
        send_scan({1'b0, KEY_CTRL});
        send_scan(8'h1E);                   // ctrl-a, first control code
        send_scan(8'h2C);                   // ctrl-z, last control code
        send_scan(8'h10);                   // ctrl with q row: normal table
        send_scan({1'b1, KEY_CTRL});
        send_scan(PREFIX_BYTE);
        send_scan(PREFIX_BYTE);             // prefix repeated
        send_scan({1'b0, KEY_ALT});         // extended alt press
        send_scan(PREFIX_BYTE);
        send_scan({1'b0, KEY_CTRL});        // extended ctrl press
        send_scan(PREFIX_BYTE);
        send_scan({1'b1, KEY_CTRL});        // extended ctrl release
        send_scan(PREFIX_BYTE);
        send_scan(8'h47);                   // some other extended key
        send_scan({1'b0, KEY_NUM});
        send_scan({1'b0, KEY_SCROLL});
        send_scan(8'hFF);                   // highest code
        sent = 25;

        // random: mostly typing with modifier and lock traffic, some prefix
        // sequences and raw noise
        while (sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 29) == 0)
                quiet = !quiet;
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                // ordinary key stroke
                tap_key(7'($urandom_range(0, 57)));
                sent += 2;
            end
            else if (r < 62)
            begin
                // modifier press or release
                case ($urandom_range(0, 3))
                    0:       key = KEY_LSHF;
                    1:       key = KEY_RSHF;
                    2:       key = KEY_CTRL;
                    default: key = KEY_ALT;
                endcase
                send_scan({1'($urandom_range(0, 1)), key});
                sent += 1;
            end
            else if (r < 72)
            begin
                // lock key stroke
                case ($urandom_range(0, 2))
                    0:       key = KEY_CAPS;
                    1:       key = KEY_NUM;
                    default: key = KEY_SCROLL;
                endcase
                tap_key(key);
                sent += 2;
            end
            else if (r < 85)
            begin
                // extended sequence, occasionally with a doubled prefix
                send_scan(PREFIX_BYTE);
                case ($urandom_range(0, 5))
                    0:       send_scan({1'b0, KEY_CTRL});
                    1:       send_scan({1'b0, KEY_ALT});
                    2:       send_scan({1'b1, KEY_CTRL});
                    3:       send_scan({1'b1, KEY_ALT});
                    4:       send_scan(PREFIX_BYTE);
                    default: send_scan(8'($urandom_range(0, 255)));
                endcase
                sent += 2;
            end
            else
            begin
                // raw noise, any byte
                send_scan(8'($urandom_range(0, 255)));
                sent += 1;
            end
        end
        scan_valid = 1'b0;
        quiet = 1'b0;

        // let every expected character come out, then a little extra
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.mismatches == 0 && board.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
